// ===== hdl/gwws_pkg.sv =====
`timescale 1ns / 1ps

package gwws_pkg;

    localparam logic [7:0]  CH_SPACE     = 8'd32;
    localparam logic [7:0]  CH_NEWLINE   = 8'd10;
    localparam logic [7:0]  CH_TERM      = 8'd0;
    localparam int unsigned WIDTH_BITS   = 17;
    localparam logic [16:0] WIDTH_MAX    = 17'h1FFFF;
    localparam logic [17:0] MARGIN_UNITS = 18'd48;

    typedef struct packed {
        logic [7:0]  char_code;
        logic [11:0] advance;
        logic        end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
    } t_out_item;

    // decision taken for one accepted item
    typedef struct packed {
        logic                  rel_nl0;
        logic                  post1_v;
        logic [7:0]            post1_byte;
        logic                  post1_last;
        logic                  post2_v;
        logic [7:0]            post2_byte;
        logic                  wr_en;
        logic [7:0]            wr_data;
        logic                  pend;
        logic [WIDTH_BITS-1:0] line_w;
        logic [WIDTH_BITS-1:0] word_w;
    } t_plan;

endpackage

// ===== hdl/gwws_hold_mem.sv =====
`timescale 1ns / 1ps

module gwws_hold_mem #(
    parameter int HOLD_DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(HOLD_DEPTH)-1:0] i_waddr,
    input  logic [7:0]                    i_wdata,
    input  logic                          i_re,
    input  logic [$clog2(HOLD_DEPTH)-1:0] i_raddr,
    output logic [7:0]                    o_rdata
);

    logic [7:0] r_mem [HOLD_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/gwws_plan.sv =====
`timescale 1ns / 1ps

module gwws_plan #(
    parameter int HOLD_DEPTH = 32
) (
    input  gwws_pkg::t_in_item                  i_item,
    input  logic [15:0]                         i_max_width,
    input  logic [gwws_pkg::WIDTH_BITS-1:0]     i_line_w,
    input  logic [gwws_pkg::WIDTH_BITS-1:0]     i_word_w,
    input  logic                                i_pend,
    input  logic [$clog2(HOLD_DEPTH+1)-1:0]     i_hold_cnt,
    output gwws_pkg::t_plan                     o_plan,
    output logic [$clog2(HOLD_DEPTH+1)-1:0]     o_rel_cnt,
    output logic [$clog2(HOLD_DEPTH)-1:0]       o_wr_addr,
    output logic [$clog2(HOLD_DEPTH+1)-1:0]     o_hold_cnt
);

    localparam int CW = $clog2(HOLD_DEPTH + 1);
    localparam int AW = $clog2(HOLD_DEPTH);

    logic [17:0]                     line_sum;
    logic [17:0]                     word_sum;
    logic [gwws_pkg::WIDTH_BITS-1:0] line_sat;
    logic [gwws_pkg::WIDTH_BITS-1:0] word_sat;
    logic                            is_sp;
    logic                            is_nl;
    logic signed [17:0]              limit;
    logic                            ovf;
    logic [CW-1:0]                   hc2;

    // saturating width accumulation
    assign line_sum = {1'b0, i_line_w} + {6'b0, i_item.advance};
    assign word_sum = {1'b0, i_word_w} + {6'b0, i_item.advance};
    assign line_sat = line_sum[17] ? gwws_pkg::WIDTH_MAX : line_sum[16:0];
    assign word_sat = word_sum[17] ? gwws_pkg::WIDTH_MAX : word_sum[16:0];

    assign is_sp = (i_item.char_code == gwws_pkg::CH_SPACE);
    assign is_nl = (i_item.char_code == gwws_pkg::CH_NEWLINE);
    assign limit = $signed({2'b0, i_max_width} - gwws_pkg::MARGIN_UNITS);

    always_comb begin
        o_plan            = '0;
        o_rel_cnt         = '0;
        o_wr_addr         = '0;
        o_hold_cnt        = '0;
        hc2               = i_hold_cnt;
        ovf               = 1'b0;
        o_plan.pend       = i_pend;
        o_plan.line_w     = line_sat;
        o_plan.word_w     = word_sat;
        o_plan.post1_byte = i_item.char_code;
        o_plan.post2_byte = i_item.char_code;
        o_plan.wr_data    = i_item.char_code;

        if (i_item.end_of_text) begin
            // flush, then terminator; line state back to reset
            o_rel_cnt         = i_hold_cnt;
            o_plan.post1_v    = 1'b1;
            o_plan.post1_byte = gwws_pkg::CH_TERM;
            o_plan.post1_last = 1'b1;
            o_plan.pend       = 1'b0;
            o_plan.line_w     = '0;
            o_plan.word_w     = '0;
        end else begin
            if (is_sp) begin
                if (i_pend) begin
                    o_rel_cnt = i_hold_cnt;
                end
                o_plan.pend   = 1'b1;
                hc2           = '0;
                o_plan.word_w = '0;
            end else if (is_nl) begin
                if (i_pend) begin
                    o_rel_cnt = i_hold_cnt;
                end
                o_plan.pend   = 1'b0;
                hc2           = '0;
                o_plan.line_w = '0;
                o_plan.word_w = '0;
            end

            ovf = $signed({1'b0, o_plan.line_w}) > limit;

            if (ovf) begin
                o_hold_cnt = '0;
                if (o_plan.pend) begin
                    o_plan.pend = 1'b0;
                    if (is_sp) begin
                        // the space itself turns into the break
                        o_plan.line_w     = '0;
                        o_plan.word_w     = '0;
                        o_plan.post1_v    = 1'b1;
                        o_plan.post1_byte = gwws_pkg::CH_NEWLINE;
                    end else begin
                        // held space becomes the break
                        o_rel_cnt      = hc2;
                        o_plan.rel_nl0 = 1'b1;
                        o_plan.line_w  = o_plan.word_w;
                        o_plan.post1_v = 1'b1;
                    end
                end else begin
                    // no break point on the line
                    o_plan.post1_v    = 1'b1;
                    o_plan.post1_byte = gwws_pkg::CH_NEWLINE;
                    o_plan.post2_v    = 1'b1;
                    o_plan.line_w     = {5'b0, i_item.advance};
                    o_plan.word_w     = '0;
                end
            end else if (o_plan.pend) begin
                if (hc2 == CW'(HOLD_DEPTH - 1)) begin
                    // store full: release unchanged, drop the break point
                    o_rel_cnt      = hc2;
                    o_plan.post1_v = 1'b1;
                    o_plan.pend    = 1'b0;
                    o_hold_cnt     = '0;
                end else begin
                    o_plan.wr_en = 1'b1;
                    o_wr_addr    = hc2[AW-1:0];
                    o_hold_cnt   = hc2 + CW'(1);
                end
            end else begin
                o_plan.post1_v = 1'b1;
                o_hold_cnt     = '0;
            end
        end
    end

endmodule

// ===== hdl/greedy_word_wrap_stream_unit.sv =====
`timescale 1ns / 1ps

// greedy word wrap over a byte stream: each input transfer carries a byte and its glyph
// advance (unsigned 8.4), and the unit breaks lines once the line width passes max_width
// minus a 3 pixel margin, turning the latest space on the line into a newline or, with no
// space, inserting a newline ahead of the byte; bytes from a pending space onward wait in
// a HOLD_DEPTH entry hold memory until their form is final, and an end_of_text transfer
// flushes them and sends a zero terminator with last set. items are taken one at a time,
// and a new item waits until the last one has sent everything; each held byte that is
// released is first read from the memory and then sent, and any newline or byte that
// follows goes out after them. the hold memory is never cleared; only entries written
// since the last release are read. max_width is written through i_cfg_we / i_cfg_wdata;
// the user must write it only while the unit is idle, which the unit itself does not
// enforce, and it resets to 65535

module greedy_word_wrap_stream_unit #(
    parameter int HOLD_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input byte stream
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  gwws_pkg::t_in_item   i_in_data,
    // output byte stream
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output gwws_pkg::t_out_item  o_out_data,
    // max_width register
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_wdata
);

    localparam int CW = $clog2(HOLD_DEPTH + 1);
    localparam int AW = $clog2(HOLD_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EM,
        S_P1,
        S_P2
    } t_state;

    // sequencer and line state
    t_state                          r_state,      n_state;
    logic [15:0]                     r_max_width,  n_max_width;
    logic [gwws_pkg::WIDTH_BITS-1:0] r_line_w,     n_line_w;
    logic [gwws_pkg::WIDTH_BITS-1:0] r_word_w,     n_word_w;
    logic                            r_pend,       n_pend;
    logic [CW-1:0]                   r_hold_cnt,   n_hold_cnt;
    // plan for the item in flight
    logic [CW-1:0]                   r_rel_cnt,    n_rel_cnt;
    logic [CW-1:0]                   r_idx,        n_idx;
    logic                            r_nl0,        n_nl0;
    logic                            r_post1_v,    n_post1_v;
    logic [7:0]                      r_post1_byte, n_post1_byte;
    logic                            r_post1_last, n_post1_last;
    logic                            r_post2_v,    n_post2_v;
    logic [7:0]                      r_post2_byte, n_post2_byte;
    logic                            r_wr_pend,    n_wr_pend;
    logic [7:0]                      r_wr_data,    n_wr_data;
    // output register
    logic                            r_out_valid,  n_out_valid;
    gwws_pkg::t_out_item             r_out,        n_out;

    gwws_pkg::t_plan                 plan;
    logic [CW-1:0]                   plan_rel_cnt;
    logic [AW-1:0]                   plan_wr_addr;
    logic [CW-1:0]                   plan_hold_cnt;

    logic                            accept;
    logic                            can_emit;
    logic                            finish;
    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    logic [7:0]                      mem_wdata;
    logic                            mem_re;
    logic [7:0]                      mem_rdata;

    gwws_plan #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_plan (
        .i_item      (i_in_data),
        .i_max_width (r_max_width),
        .i_line_w    (r_line_w),
        .i_word_w    (r_word_w),
        .i_pend      (r_pend),
        .i_hold_cnt  (r_hold_cnt),
        .o_plan      (plan),
        .o_rel_cnt   (plan_rel_cnt),
        .o_wr_addr   (plan_wr_addr),
        .o_hold_cnt  (plan_hold_cnt)
    );

    gwws_hold_mem #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_hold_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // a new item only enters once the previous one has sent everything
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    // output register is free or empties this cycle
    assign can_emit   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_max_width  = r_max_width;
        n_line_w     = r_line_w;
        n_word_w     = r_word_w;
        n_pend       = r_pend;
        n_hold_cnt   = r_hold_cnt;
        n_rel_cnt    = r_rel_cnt;
        n_idx        = r_idx;
        n_nl0        = r_nl0;
        n_post1_v    = r_post1_v;
        n_post1_byte = r_post1_byte;
        n_post1_last = r_post1_last;
        n_post2_v    = r_post2_v;
        n_post2_byte = r_post2_byte;
        n_wr_pend    = r_wr_pend;
        n_wr_data    = r_wr_data;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        finish       = 1'b0;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = plan_wr_addr;
        mem_wdata    = plan.wr_data;

        if (i_cfg_we) begin
            n_max_width = i_cfg_wdata;
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_line_w     = plan.line_w;
                    n_word_w     = plan.word_w;
                    n_pend       = plan.pend;
                    n_hold_cnt   = plan_hold_cnt;
                    n_rel_cnt    = plan_rel_cnt;
                    n_idx        = '0;
                    n_nl0        = plan.rel_nl0;
                    n_post1_v    = plan.post1_v;
                    n_post1_byte = plan.post1_byte;
                    n_post1_last = plan.post1_last;
                    n_post2_v    = plan.post2_v;
                    n_post2_byte = plan.post2_byte;
                    n_wr_data    = plan.wr_data;
                    n_wr_pend    = 1'b0;
                    if (plan_rel_cnt != '0) begin
                        // store write waits until the old entries are out
                        n_wr_pend = plan.wr_en;
                        n_state   = S_RD;
                    end else begin
                        mem_we = plan.wr_en;
                        if (plan.post1_v) begin
                            n_state = S_P1;
                        end
                    end
                end
            end
            S_RD: begin
                mem_re  = 1'b1;
                n_state = S_EM;
            end
            S_EM: begin
                if (can_emit) begin
                    n_out_valid   = 1'b1;
                    n_out.last    = 1'b0;
                    n_out.char_out = (r_idx == '0 && r_nl0) ? gwws_pkg::CH_NEWLINE
                                                             : mem_rdata;
                    n_idx = r_idx + CW'(1);
                    if (r_idx + CW'(1) == r_rel_cnt) begin
                        if (r_post1_v) begin
                            n_state = S_P1;
                        end else begin
                            finish = 1'b1;
                        end
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_P1: begin
                if (can_emit) begin
                    n_out_valid    = 1'b1;
                    n_out.char_out = r_post1_byte;
                    n_out.last     = r_post1_last;
                    if (r_post2_v) begin
                        n_state = S_P2;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            S_P2: begin
                if (can_emit) begin
                    n_out_valid    = 1'b1;
                    n_out.char_out = r_post2_byte;
                    n_out.last     = 1'b0;
                    finish         = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // item done: deferred store write lands at entry 0 (the new pending space)
        if (finish) begin
            n_state   = S_IDLE;
            n_wr_pend = 1'b0;
            if (r_wr_pend) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = r_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_width <= 16'hFFFF;
            r_line_w    <= '0;
            r_word_w    <= '0;
            r_pend      <= 1'b0;
            r_hold_cnt  <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_max_width <= n_max_width;
            r_line_w    <= n_line_w;
            r_word_w    <= n_word_w;
            r_pend      <= n_pend;
            r_hold_cnt  <= n_hold_cnt;
            r_wr_pend   <= n_wr_pend;
            r_out_valid <= n_out_valid;
        end
        r_rel_cnt    <= n_rel_cnt;
        r_idx        <= n_idx;
        r_nl0        <= n_nl0;
        r_post1_v    <= n_post1_v;
        r_post1_byte <= n_post1_byte;
        r_post1_last <= n_post1_last;
        r_post2_v    <= n_post2_v;
        r_post2_byte <= n_post2_byte;
        r_wr_data    <= n_wr_data;
        r_out        <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== bench/wrap_checker.sv =====
`timescale 1ns / 1ps

module wrap_checker #(
    parameter int HOLD_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  gwws_pkg::t_in_item   i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  gwws_pkg::t_out_item  i_out_data,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_wdata,
    output int                   o_fail_count,
    output int                   o_owed
);

    logic [15:0]                     max_width = 16'hFFFF;
    logic [gwws_pkg::WIDTH_BITS-1:0] line_w = '0;
    logic [gwws_pkg::WIDTH_BITS-1:0] word_w = '0;
    logic                            space_pending = 1'b0;
    logic [7:0]                      held_bytes[$];
    gwws_pkg::t_out_item             expected_bytes[$];
    int                              fails = 0;

    function automatic logic [gwws_pkg::WIDTH_BITS-1:0] add_sat(
        logic [gwws_pkg::WIDTH_BITS-1:0] a, logic [11:0] b);
        logic [gwws_pkg::WIDTH_BITS:0] s;
        s = {1'b0, a} + (gwws_pkg::WIDTH_BITS+1)'(b);
        return (s > (gwws_pkg::WIDTH_BITS+1)'(gwws_pkg::WIDTH_MAX)) ? gwws_pkg::WIDTH_MAX
                                                                    : s[gwws_pkg::WIDTH_BITS-1:0];
    endfunction

    function automatic void emit(logic [7:0] ch, logic lst);
        gwws_pkg::t_out_item r;
        r.char_out = ch;
        r.last     = lst;
        expected_bytes.push_back(r);
    endfunction

    function automatic void flush_held();
        foreach (held_bytes[i]) emit(held_bytes[i], 1'b0);
        held_bytes.delete();
    endfunction

    function automatic void clear_line();
        line_w        = '0;
        word_w        = '0;
        space_pending = 1'b0;
        held_bytes.delete();
    endfunction

    // works out the output bytes caused by one input transfer
    function automatic void predict_wrap(gwws_pkg::t_in_item it);
        logic [7:0]  ch;
        logic [11:0] adv;
        int          limit;
        if (it.end_of_text) begin
            flush_held();
            emit(gwws_pkg::CH_TERM, 1'b1);
            clear_line();
            return;
        end
        ch     = it.char_code;
        adv    = it.advance;
        line_w = add_sat(line_w, adv);
        word_w = add_sat(word_w, adv);
        if (ch == gwws_pkg::CH_SPACE) begin
            if (space_pending) flush_held();
            space_pending = 1'b1;
            held_bytes.delete();
            word_w = '0;
        end else if (ch == gwws_pkg::CH_NEWLINE) begin
            if (space_pending) flush_held();
            space_pending = 1'b0;
            line_w = '0;
            word_w = '0;
        end
        limit = int'(max_width) - int'(gwws_pkg::MARGIN_UNITS);
        if (int'(line_w) > limit) begin
            if (space_pending) begin
                space_pending = 1'b0;
                if (ch == gwws_pkg::CH_SPACE) begin
                    // the wrapping space itself turns into the newline
                    line_w = '0;
                    word_w = '0;
                    emit(gwws_pkg::CH_NEWLINE, 1'b0);
                    return;
                end
                if (held_bytes.size() > 0) held_bytes[0] = gwws_pkg::CH_NEWLINE;
                flush_held();
                line_w = word_w;
                emit(ch, 1'b0);
                return;
            end
            emit(gwws_pkg::CH_NEWLINE, 1'b0);
            line_w = gwws_pkg::WIDTH_BITS'(adv);
            word_w = '0;
            emit(ch, 1'b0);
            return;
        end
        if (space_pending) begin
            held_bytes.push_back(ch);
            if (held_bytes.size() >= HOLD_DEPTH) begin
                flush_held();
                space_pending = 1'b0;
            end
            return;
        end
        emit(ch, 1'b0);
    endfunction

    always @(posedge i_clk) begin
        gwws_pkg::t_out_item want;
        if (!i_rst_n) begin
            max_width = 16'hFFFF;
            clear_line();
            expected_bytes.delete();
        end else begin
            if (i_in_valid && !i_in_stall) predict_wrap(i_in_data);
            if (i_cfg_we) max_width = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected output: char_out %0d last %0d",
                           i_out_data.char_out, i_out_data.last);
                    fails++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out_data.char_out !== want.char_out) begin
                        $error("char_out expected %0d actual %0d",
                               want.char_out, i_out_data.char_out);
                        fails++;
                    end
                    if (i_out_data.last !== want.last) begin
                        $error("last expected %0d actual %0d", want.last, i_out_data.last);
                        fails++;
                    end
                end
            end
        end
        o_owed       <= expected_bytes.size();
        o_fail_count <= fails;
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int HOLD_DEPTH      = 32;
    localparam int GAP_MAX         = 17;
    // extra wait after the output drains, for an item that only joins the hold memory
    localparam int SETTLE_CYCLES   = 20;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int IDLE_LIMIT      = 4000;
    localparam int PHASE_ITEMS     = 73;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    gwws_pkg::t_in_item  in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    gwws_pkg::t_out_item out_data;
    logic                cfg_we    = 1'b0;
    logic [15:0]         cfg_wdata = '0;

    int          fail_count;
    int          owed;
    bit          hold_req    = 1'b0;
    bit          hold_done   = 1'b0;
    int          idle_cycles = 0;
    // mirrors max_width so that glyph advances can be scaled to the line
    logic [15:0] width_now   = 16'hFFFF;

    always #5 clk = ~clk;

    greedy_word_wrap_stream_unit #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // watches both channels, predicts every output byte and compares
    wrap_checker #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_wrap_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_owed       (owed)
    );

    // watchdog: too long without any transfer on either channel ends the run
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stall before each output transfer, and on request one
    // long hold-off so that the unit backs up and stalls its input
    initial begin
        int pause;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                pause = $urandom_range(0, GAP_MAX);
                if (pause > 0) begin
                    out_stall <= 1'b1;
                    repeat (pause) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // one input transfer after a random gap; valid stays high when the gap is zero
    task automatic offer_item(gwws_pkg::t_in_item it);
        int gap;
        gap = $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
    endtask

    // sender goes quiet until every predicted byte has come out, then waits out
    // SETTLE_CYCLES for any item still being taken into the hold memory
    task automatic settle_out();
        in_valid <= 1'b0;
        do @(posedge clk); while (owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_width(logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        width_now = value;
    endtask

    function automatic gwws_pkg::t_in_item byte_item(logic [7:0] ch, logic [11:0] adv);
        gwws_pkg::t_in_item it;
        it.char_code   = ch;
        it.advance     = adv;
        it.end_of_text = 1'b0;
        return it;
    endfunction

    // end of text with junk in the ignored fields
    function automatic gwws_pkg::t_in_item end_item();
        gwws_pkg::t_in_item it;
        it.char_code   = 8'($urandom_range(0, 255));
        it.advance     = 12'($urandom_range(0, 4095));
        it.end_of_text = 1'b1;
        return it;
    endfunction

    // glyph advances of up to a sixth of the line, so that wraps come often
    function automatic logic [11:0] draw_advance();
        int hi;
        hi = int'(width_now) / 6;
        if (hi < 32) hi = 32;
        if (hi > 4095) hi = 4095;
        return 12'($urandom_range(0, hi));
    endfunction

    // words of printable bytes split by spaces and newlines, with some noise
    // and some end items; long words with narrow glyphs fill the hold memory
    task automatic send_text(int count);
        int sent;
        int len;
        int pick;
        bit narrow;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                offer_item(end_item());
                sent++;
            end else if (pick < 10) begin
                offer_item(byte_item(8'($urandom_range(0, 255)),
                                     12'($urandom_range(0, 4095))));
                sent++;
            end else begin
                len    = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40)
                                                      : $urandom_range(1, 8);
                narrow = ($urandom_range(0, 3) == 0);
                repeat (len) begin
                    offer_item(byte_item(8'($urandom_range(33, 255)),
                                         narrow ? 12'($urandom_range(0, 15))
                                                : draw_advance()));
                    sent++;
                end
                offer_item(byte_item(($urandom_range(0, 4) == 0) ? gwws_pkg::CH_NEWLINE
                                                                 : gwws_pkg::CH_SPACE,
                                     draw_advance()));
                sent++;
            end
        end
    endtask

    initial begin
        logic [15:0] widths[6];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain bytes at the field extremes, a space held and released by a
        // newline, and a second space while one is pending
        write_max_width(16'hFFFF);
        offer_item(byte_item(8'h00, 12'h000));
        offer_item(byte_item(8'hFF, 12'hFFF));
        offer_item(byte_item(gwws_pkg::CH_SPACE, 12'd16));
        offer_item(byte_item(8'h62, 12'd16));
        offer_item(byte_item(gwws_pkg::CH_NEWLINE, 12'd16));
        offer_item(byte_item(gwws_pkg::CH_SPACE, 12'd16));
        offer_item(byte_item(gwws_pkg::CH_SPACE, 12'd16));
        offer_item(byte_item(8'h63, 12'd16));
        offer_item(end_item());
        settle_out();

        // 10 pixel line: wrap at a pending space, wrap with no space, and a
        // space that itself overflows the line
        write_max_width(16'd208);
        offer_item(byte_item(8'h61, 12'd64));
        offer_item(byte_item(8'h62, 12'd64));
        offer_item(byte_item(gwws_pkg::CH_SPACE, 12'd16));
        offer_item(byte_item(8'h63, 12'd64));
        offer_item(byte_item(8'h64, 12'd64));
        offer_item(byte_item(8'h65, 12'd64));
        offer_item(byte_item(gwws_pkg::CH_SPACE, 12'd112));
        offer_item(byte_item(8'h66, 12'hFFF));
        offer_item(end_item());
        settle_out();

        // negative limit: a newline byte comes out as two newlines
        write_max_width(16'd0);
        offer_item(byte_item(gwws_pkg::CH_NEWLINE, 12'd0));
        offer_item(byte_item(8'h78, 12'd0));
        offer_item(end_item());
        settle_out();

        widths[0] = 16'hFFFF;
        widths[1] = 16'($urandom_range(300, 1500));
        widths[2] = 16'd0;
        widths[3] = 16'd48;
        widths[4] = 16'($urandom_range(0, 65535));
        widths[5] = 16'($urandom_range(100, 800));

        foreach (widths[p]) begin
            write_max_width(widths[p]);
            if (p == 1) hold_req = 1'b1;
            if (p == 2) begin
                // sender pauses mid-text until everything has drained
                send_text(PHASE_ITEMS / 2);
                settle_out();
                send_text(PHASE_ITEMS - PHASE_ITEMS / 2);
            end else begin
                send_text(PHASE_ITEMS);
            end
            settle_out();
        end

        if (fail_count == 0 && owed == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
